### sv/hex_to_spiral_index_assert.svh
// Assertion macros shared by the spiral index converter.
`ifndef HEX_TO_SPIRAL_INDEX_ASSERT_SVH
`define HEX_TO_SPIRAL_INDEX_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define H2S_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication with a fixed number of cycles between cause and effect.
`define H2S_ASSERT_AFTER(name, ante, cycles, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##cycles (cons)) else $error(msg);

`endif

### sv/h2s_pkg.sv
// Types and constants shared by the spiral index converter modules.
package h2s_pkg;

   // Division by three as a multiply by ceil(2^13 / 3) and a shift by 13.
   localparam int DIV3_RECIP = 2731;
   localparam int DIV3_SHIFT = 13;

   // Cycles from an accepted transaction to its result strobe.
   localparam int LATENCY = 4;

   typedef enum logic [2:0] {
      SEC_0 = 3'd0,
      SEC_1 = 3'd1,
      SEC_2 = 3'd2,
      SEC_3 = 3'd3,
      SEC_4 = 3'd4,
      SEC_5 = 3'd5
   } sector_type;

   // First stage: folded magnitude of x and its scaled product.
   typedef struct packed {
      logic               neg_x;
      logic [12:0]        ax;
      logic [24:0]        prod;
      logic signed [11:0] y;
   } fold_type;

   // Second stage: sector, ring and step before the range check.
   typedef struct packed {
      logic       bad;
      sector_type sec;
      logic [10:0] ring;
      logic [10:0] step;
   } polar_type;

endpackage

### sv/h2s_fold.sv
// Input stage: takes a transaction, folds x to a magnitude and scales it by 1/3.
module h2s_fold (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [12:0] hex_x,
   input  logic signed [11:0] hex_y,
   output logic               busy,
   output logic               valid,
   output h2s_pkg::fold_type  fold
);
   import h2s_pkg::*;

   logic     busy_ff;
   logic     valid_ff;
   fold_type fold_ff;
   fold_type fold_in;
   logic [12:0] ax;

   assign ax = hex_x[12] ? 13'(-hex_x) : 13'(hex_x);

   always_comb begin
      fold_in.neg_x = hex_x[12];
      fold_in.ax    = ax;
      fold_in.prod  = 25'(ax) * 25'(DIV3_RECIP);
      fold_in.y     = hex_y;
   end

   // The pipeline never stalls, so busy is high only during reset and the cycle after it.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= start && !busy_ff;
      end
      fold_ff <= fold_in;
   end

   assign busy  = busy_ff;
   assign valid = valid_ff;
   assign fold  = fold_ff;

endmodule

### sv/h2s_sector.sv
// Second stage: column, divisibility check, sector choice, ring and step.
module h2s_sector (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  h2s_pkg::fold_type  fold,
   output logic               valid,
   output h2s_pkg::polar_type polar
);
   import h2s_pkg::*;

   logic               valid_ff;
   polar_type          polar_ff;
   polar_type          polar_in;
   logic [10:0]        qm;
   logic [12:0]        rem;
   logic signed [11:0] q_pos;
   logic signed [11:0] q;
   logic signed [11:0] nq;
   logic signed [11:0] y;
   logic [11:0]        ay;
   logic [12:0]        sum_a;
   logic [11:0]        diff_a;
   logic signed [12:0] s;
   logic [11:0]        as;
   logic               origin;
   sector_type         sec;

   assign qm     = fold.prod[DIV3_SHIFT +: 11];
   assign rem    = fold.ax - 13'(13'(qm) * 13'd3);
   assign q_pos  = $signed({1'b0, qm});
   assign q      = fold.neg_x ? -q_pos : q_pos;
   assign nq     = -q;
   assign y      = fold.y;
   assign ay     = y[11] ? 12'(-y) : 12'(y);
   assign sum_a  = 13'(ay) + 13'(qm);
   assign diff_a = ay - 12'(qm);
   assign s      = 13'(q) + 13'(y);
   assign as     = s[12] ? 12'(-s) : 12'(s);

   always_comb begin
      origin = 1'b0;
      if (q > 12'sd0) begin
         if (y >= q)       sec = SEC_0;
         else if (y < nq)  sec = SEC_4;
         else              sec = SEC_5;
      end else if (q < 12'sd0) begin
         if (y > nq)       sec = SEC_1;
         else if (y <= q)  sec = SEC_3;
         else              sec = SEC_2;
      end else begin
         if (y > 12'sd0)      sec = SEC_1;
         else if (y < 12'sd0) sec = SEC_4;
         else begin
            sec    = SEC_0;
            origin = 1'b1;
         end
      end
   end

   // In sectors 0, 1, 3 and 4 the y magnitude is never below the column
   // magnitude, so the truncating halves reduce to right shifts.
   always_comb begin
      polar_in.bad = (rem != 13'd0);
      polar_in.sec = sec;
      case (sec) inside
         SEC_1, SEC_4: begin
            polar_in.ring = sum_a[11:1];
            polar_in.step = qm;
         end
         SEC_0, SEC_3: begin
            polar_in.ring = sum_a[11:1];
            polar_in.step = diff_a[11:1];
         end
         SEC_2, SEC_5: begin
            polar_in.ring = qm;
            polar_in.step = as[11:1];
         end
         default: begin
            polar_in.ring = 11'd0;
            polar_in.step = 11'd0;
         end
      endcase
      if (origin) begin
         polar_in.ring = 11'd0;
         polar_in.step = 11'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      polar_ff <= polar_in;
   end

   assign valid = valid_ff;
   assign polar = polar_ff;

endmodule

### sv/h2s_index.sv
// Last two stages: ring range check, ring products and the spiral index sum.
module h2s_index #(
   parameter int MAX_RADIUS = 1023
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  h2s_pkg::polar_type polar,
   output logic               valid,
   output logic [21:0]        spiral_index,
   output logic [2:0]         sector,
   output logic [9:0]         ring_step,
   output logic [9:0]         ring,
   output logic               bad_input
);
   import h2s_pkg::*;

   // Third stage registers.
   logic        s3_valid_ff;
   logic        s3_bad_ff;
   logic        s3_zero_ff;
   logic [2:0]  s3_sec_ff;
   logic [10:0] s3_ring_ff;
   logic [10:0] s3_step_ff;
   logic [21:0] s3_rr_ff;
   logic [13:0] s3_sr_ff;
   logic        over;

   // Output registers.
   logic        valid_ff;
   logic [21:0] index_ff;
   logic [21:0] index_in;
   logic [2:0]  sector_ff;
   logic [9:0]  step_ff;
   logic [9:0]  ring_ff;
   logic        bad_ff;
   logic [21:0] idx_sum;

   assign over = 16'(polar.ring) > 16'(MAX_RADIUS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= valid_in;
      end
      s3_bad_ff  <= polar.bad || over;
      s3_zero_ff <= (polar.ring == 11'd0);
      s3_sec_ff  <= 3'(polar.sec);
      s3_ring_ff <= polar.ring;
      s3_step_ff <= polar.step;
      s3_rr_ff   <= 22'(polar.ring) * 22'(polar.ring - 11'd1);
      s3_sr_ff   <= 14'(polar.sec) * 14'(polar.ring);
   end

   // The index wraps to its field width, which matches taking the full sum.
   assign idx_sum  = 22'd1 + (s3_rr_ff * 22'd3) + 22'(s3_sr_ff) + 22'(s3_step_ff);
   assign index_in = s3_zero_ff ? 22'd0 : idx_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s3_valid_ff;
      end
      if (s3_bad_ff) begin
         index_ff  <= 22'd0;
         sector_ff <= 3'd0;
         step_ff   <= 10'd0;
         ring_ff   <= 10'd0;
         bad_ff    <= 1'b1;
      end else begin
         index_ff  <= index_in;
         sector_ff <= s3_sec_ff;
         step_ff   <= s3_step_ff[9:0];
         ring_ff   <= s3_ring_ff[9:0];
         bad_ff    <= 1'b0;
      end
   end

   assign valid        = valid_ff;
   assign spiral_index = index_ff;
   assign sector       = sector_ff;
   assign ring_step    = step_ff;
   assign ring         = ring_ff;
   assign bad_input    = bad_ff;

endmodule

### sv/hex_to_spiral_index.sv
// Top level of the hex coordinate to spiral index converter.
//
//   port group   direction  handshake            payload
//   req_         in         start high, busy low  req_hex_x, req_hex_y
//   rsp_         out        rsp_valid strobe      rsp_spiral_index, rsp_sector,
//                                                 rsp_ring_step, rsp_ring,
//                                                 rsp_bad_input
//
// One transaction can be taken on every clock while busy is low; four register
// stages lie between the accepting edge and the result strobe.
// The stage split follows the divide-by-three multiply and the ring product
// multiply, each followed by a register.
// Synchronous reset empties the pipeline and holds busy high through the cycle after it.
// The receiver cannot stall, so busy never rises outside reset.
module hex_to_spiral_index #(
   parameter int MAX_RADIUS = 1023
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [12:0] req_hex_x,
   input  logic signed [11:0] req_hex_y,
   output logic               rsp_valid,
   output logic [21:0]        rsp_spiral_index,
   output logic [2:0]         rsp_sector,
   output logic [9:0]         rsp_ring_step,
   output logic [9:0]         rsp_ring,
   output logic               rsp_bad_input
);
   import h2s_pkg::*;

   `include "hex_to_spiral_index_assert.svh"

   logic      fold_valid;
   fold_type  fold;
   logic      polar_valid;
   polar_type polar;

   h2s_fold u_fold (
      .clock (clock),
      .reset (reset),
      .start (start),
      .hex_x (req_hex_x),
      .hex_y (req_hex_y),
      .busy  (busy),
      .valid (fold_valid),
      .fold  (fold)
   );

   h2s_sector u_sector (
      .clock    (clock),
      .reset    (reset),
      .valid_in (fold_valid),
      .fold     (fold),
      .valid    (polar_valid),
      .polar    (polar)
   );

   h2s_index #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_index (
      .clock        (clock),
      .reset        (reset),
      .valid_in     (polar_valid),
      .polar        (polar),
      .valid        (rsp_valid),
      .spiral_index (rsp_spiral_index),
      .sector       (rsp_sector),
      .ring_step    (rsp_ring_step),
      .ring         (rsp_ring),
      .bad_input    (rsp_bad_input)
   );

   `H2S_ASSERT_AFTER(a_result_follows, start && !busy, LATENCY, rsp_valid,
      "accepted transaction produced no result")
   `H2S_ASSERT_IMPLY(a_result_has_cause, rsp_valid, $past(start && !busy, LATENCY),
      "result strobe without an accepted transaction")
   `H2S_ASSERT_IMPLY(a_bad_clears_fields, rsp_valid && rsp_bad_input,
      rsp_spiral_index == 22'd0 && rsp_sector == 3'd0 &&
      rsp_ring_step == 10'd0 && rsp_ring == 10'd0,
      "rejected transaction carries nonzero fields")

endmodule
